>>> sv/ndc_pkg.sv
// ----------------------------------------------------------------------------
// ndc_pkg: shared types and constants of the nearest date chooser
// Field widths, reciprocal constants, the month tables and the verdict codes.
// ----------------------------------------------------------------------------
package ndc_pkg;

    localparam int DATE_W   = 27;   // packed YYYYMMDD value
    localparam int YEAR_W   = 14;   // year up to 13421
    localparam int REM_W    = 14;   // MMDD part, below 10000
    localparam int MON_W    = 7;    // month field, 0 to 99
    localparam int DAY_W    = 7;    // day field, 0 to 99
    localparam int Q100_W   = 8;    // year / 100, up to 134
    localparam int DAYNUM_W = 23;   // day count from year 1
    localparam int MOFF_W   = 12;   // month offset, up to 3031

    // Reciprocal for / 10000 of a 27-bit value: exact over the whole range
    localparam int              DIV10K_K_W   = 28;
    localparam int              DIV10K_PROD_W = DATE_W + DIV10K_K_W;
    localparam logic [DIV10K_K_W-1:0] DIV10K_MUL = 28'd219902326;
    localparam int              DIV10K_SHIFT = 41;

    // Reciprocal for / 100 of the 14-bit MMDD part
    localparam int              DIVR_K_W   = 15;
    localparam int              DIVR_PROD_W = REM_W + DIVR_K_W;
    localparam logic [DIVR_K_W-1:0] DIVR_MUL = 15'd10486;
    localparam int              DIVR_SHIFT = 20;

    // Reciprocal for / 100 of a 14-bit year
    localparam int              DIVY_K_W   = 15;
    localparam int              DIVY_PROD_W = YEAR_W + DIVY_K_W;
    localparam logic [DIVY_K_W-1:0] DIVY_MUL = 15'd20972;
    localparam int              DIVY_SHIFT = 21;

    // Pipeline shape
    localparam int LANE_STAGES = 5;
    localparam int CMP_STAGES  = 2;
    localparam int PIPE_DEPTH  = LANE_STAGES + CMP_STAGES;

    typedef enum logic [1:0] {
        VERDICT_EQUAL  = 2'd0,
        VERDICT_FIRST  = 2'd1,
        VERDICT_SECOND = 2'd2
    } verdict_t;

    typedef struct packed {
        logic                ok;
        logic [DAYNUM_W-1:0] day_num;
    } lane_result_t;

    // Days before month m in a common year, months 1 to 13
    localparam logic [MOFF_W-1:0] CUM_DAYS [0:13] = '{
        12'd0,   12'd0,   12'd31,  12'd59,  12'd90,  12'd120, 12'd151,
        12'd181, 12'd212, 12'd243, 12'd273, 12'd304, 12'd334, 12'd365
    };

    // Month offset before the leap day; months past December count 31 days
    function automatic logic [MOFF_W-1:0] month_base(input logic [MON_W-1:0] m);
        logic [MOFF_W-1:0] off;
        if (m == '0) begin
            off = '0;
        end else if (m <= 7'd13) begin
            off = CUM_DAYS[m[3:0]];
        end else begin
            off = 12'd365 + MOFF_W'(m - 7'd13) * 12'd31;
        end
        return off;
    endfunction

    function automatic logic [4:0] month_len(input logic [MON_W-1:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            7'd2:                    len = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> sv/ndc_date_lane.sv
// ----------------------------------------------------------------------------
// ndc_date_lane: date check and day count
// Five-stage pipe: split YYYYMMDD by reciprocal multiplies, derive the leap
// flag, sum year, month and day parts and check the calendar fields.
// ----------------------------------------------------------------------------
module ndc_date_lane (
    input  logic                                 aclk,
    input  logic [ndc_pkg::LANE_STAGES-1:0]      stage_en,
    input  logic [ndc_pkg::DATE_W-1:0]           date_in,
    output ndc_pkg::lane_result_t                result
);
    import ndc_pkg::*;

    // stage 1
    logic [DATE_W-1:0]        date1_reg;
    logic [DIV10K_PROD_W-1:0] prod1_reg;
    // stage 2
    logic [YEAR_W-1:0]        year2_reg;
    logic [REM_W-1:0]         rem2_reg;
    // stage 3
    logic [YEAR_W-1:0]        year3_reg;
    logic [YEAR_W-1:0]        prev3_reg;
    logic [REM_W-1:0]         rem3_reg;
    logic [MON_W-1:0]         mon3_reg;
    logic [Q100_W-1:0]        qy3_reg;
    logic [Q100_W-1:0]        qp3_reg;
    // stage 4
    logic                     ynz4_reg;
    logic                     leap4_reg;
    logic [MON_W-1:0]         mon4_reg;
    logic [DAY_W-1:0]         day4_reg;
    logic [DAYNUM_W-1:0]      ydays4_reg;
    // stage 5
    lane_result_t             res5_reg;

    logic [DATE_W-1:0]        rem2_full;
    logic [DIVR_PROD_W-1:0]   mon_prod;
    logic [DIVY_PROD_W-1:0]   qy_prod;
    logic [DIVY_PROD_W-1:0]   qp_prod;
    logic [YEAR_W-1:0]        prev_year;
    logic [REM_W-1:0]         day_full;
    logic                     hundred;
    logic                     leap;
    logic [DAYNUM_W-1:0]      ydays;
    logic [MOFF_W-1:0]        moff;
    logic                     ok;

    // Stage 2: remainder after the year
    assign rem2_full = date1_reg
                     - DATE_W'(prod1_reg[DIV10K_PROD_W-1:DIV10K_SHIFT]) * DATE_W'(10000);

    // Stage 3: month, and year / 100 for both the year and the year before
    assign prev_year = year2_reg - YEAR_W'(1);
    assign mon_prod  = DIVR_PROD_W'(rem2_reg) * DIVR_PROD_W'(DIVR_MUL);
    assign qy_prod   = DIVY_PROD_W'(year2_reg) * DIVY_PROD_W'(DIVY_MUL);
    assign qp_prod   = DIVY_PROD_W'(prev_year) * DIVY_PROD_W'(DIVY_MUL);

    // Stage 4: day, leap flag, days of all earlier years
    assign day_full = rem3_reg - REM_W'(mon3_reg) * REM_W'(100);
    assign hundred  = (year3_reg == YEAR_W'(YEAR_W'(qy3_reg) * YEAR_W'(100)));
    assign leap     = ((year3_reg[1:0] == 2'b00) && !hundred)
                   || (hundred && (qy3_reg[1:0] == 2'b00));
    assign ydays    = DAYNUM_W'(prev3_reg) * DAYNUM_W'(365)
                    + DAYNUM_W'(prev3_reg >> 2)
                    - DAYNUM_W'(qp3_reg)
                    + DAYNUM_W'(qp3_reg >> 2);

    // Stage 5: month offset and calendar check
    assign moff = month_base(mon4_reg)
                + MOFF_W'((mon4_reg > 7'd2) && leap4_reg);
    assign ok   = ynz4_reg && (mon4_reg >= 7'd1) && (mon4_reg <= 7'd12)
               && (day4_reg >= 7'd1)
               && (day4_reg <= DAY_W'(month_len(mon4_reg, leap4_reg)));

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            date1_reg <= date_in;
            prod1_reg <= DIV10K_PROD_W'(date_in) * DIV10K_PROD_W'(DIV10K_MUL);
        end
        if (stage_en[1]) begin
            year2_reg <= prod1_reg[DIV10K_PROD_W-1:DIV10K_SHIFT];
            rem2_reg  <= rem2_full[REM_W-1:0];
        end
        if (stage_en[2]) begin
            year3_reg <= year2_reg;
            prev3_reg <= prev_year;
            rem3_reg  <= rem2_reg;
            mon3_reg  <= mon_prod[DIVR_SHIFT+MON_W-1:DIVR_SHIFT];
            qy3_reg   <= qy_prod[DIVY_SHIFT+Q100_W-1:DIVY_SHIFT];
            qp3_reg   <= qp_prod[DIVY_SHIFT+Q100_W-1:DIVY_SHIFT];
        end
        if (stage_en[3]) begin
            ynz4_reg   <= (year3_reg != '0);
            leap4_reg  <= leap;
            mon4_reg   <= mon3_reg;
            day4_reg   <= day_full[DAY_W-1:0];
            // year zero adds no earlier years
            ydays4_reg <= (year3_reg != '0) ? ydays : '0;
        end
        if (stage_en[4]) begin
            res5_reg.ok      <= ok;
            res5_reg.day_num <= ydays4_reg + DAYNUM_W'(moff) + DAYNUM_W'(day4_reg);
        end
    end

    assign result = res5_reg;

endmodule

>>> sv/ndc_compare.sv
// ----------------------------------------------------------------------------
// ndc_compare: distance compare
// Two stages: absolute distances to the current date, then the verdict.
// ----------------------------------------------------------------------------
module ndc_compare (
    input  logic                              aclk,
    input  logic [ndc_pkg::CMP_STAGES-1:0]    stage_en,
    input  ndc_pkg::lane_result_t             cur,
    input  ndc_pkg::lane_result_t             fst,
    input  ndc_pkg::lane_result_t             snd,
    output logic                              current_ok,
    output logic                              first_ok,
    output logic                              second_ok,
    output ndc_pkg::verdict_t                 verdict
);
    import ndc_pkg::*;

    logic [DAYNUM_W-1:0] dist1_reg;
    logic [DAYNUM_W-1:0] dist2_reg;
    logic [2:0]          ok6_reg;
    logic [2:0]          ok7_reg;
    verdict_t            verdict_reg;

    logic [DAYNUM_W-1:0] dist1;
    logic [DAYNUM_W-1:0] dist2;
    verdict_t            verdict_next;

    assign dist1 = (fst.day_num >= cur.day_num) ? fst.day_num - cur.day_num
                                                : cur.day_num - fst.day_num;
    assign dist2 = (snd.day_num >= cur.day_num) ? snd.day_num - cur.day_num
                                                : cur.day_num - snd.day_num;

    always_comb begin
        if (dist1_reg == dist2_reg) begin
            verdict_next = VERDICT_EQUAL;
        end else if (dist1_reg < dist2_reg) begin
            verdict_next = VERDICT_FIRST;
        end else begin
            verdict_next = VERDICT_SECOND;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dist1_reg <= dist1;
            dist2_reg <= dist2;
            ok6_reg   <= {cur.ok, fst.ok, snd.ok};
        end
        if (stage_en[1]) begin
            ok7_reg     <= ok6_reg;
            verdict_reg <= verdict_next;
        end
    end

    assign current_ok = ok7_reg[2];
    assign first_ok   = ok7_reg[1];
    assign second_ok  = ok7_reg[0];
    assign verdict    = verdict_reg;

endmodule

>>> sv/nearest_date_chooser.sv
// ----------------------------------------------------------------------------
// nearest_date_chooser: pick the candidate date nearer to a current date
// Takes a current date and two candidates, each as packed decimal YYYYMMDD,
// flags each as a valid calendar date or not, and reports which candidate
// lies nearer in days (or that both are equally near).
//
// Usage:
//   Input channel s_valid/s_ready carries one transaction of three dates.
//   Result channel m_valid/m_ready returns exactly one transaction for each,
//   in order: three validity flags and a verdict (equal, first, second).
//   Invalid dates are still converted and compared.
// Pipeline: five stages per date (the field split by reciprocal multiplies,
//   the leap and year-sum stage, the month-table stage), then two compare
//   stages.
// Throughput: one transaction per cycle while m_ready stays high.
// Reset: aresetn low on a clock edge empties the pipe; m_valid drops and no
//   transaction in flight survives.
// Stall: when m_ready is low the final stage holds its result; earlier stages
//   keep advancing into empty slots, so s_ready stays high while any bubble
//   remains and falls only once every stage holds a transaction.
// ----------------------------------------------------------------------------
module nearest_date_chooser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ndc_pkg::DATE_W-1:0]   s_current_date,
    input  logic [ndc_pkg::DATE_W-1:0]   s_first_date,
    input  logic [ndc_pkg::DATE_W-1:0]   s_second_date,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_current_ok,
    output logic                         m_first_ok,
    output logic                         m_second_ok,
    output logic [1:0]                   m_verdict
);
    import ndc_pkg::*;

    // One valid bit per stage, travelling with the data
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    // Stage enables: a stage loads when it is empty or its contents move on
    logic [PIPE_DEPTH-1:0] stage_en;

    lane_result_t cur_res;
    lane_result_t fst_res;
    lane_result_t snd_res;
    verdict_t     verdict;

    always_comb begin
        stage_en[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || m_ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    assign s_ready = stage_en[0];

    // Advance each valid bit with its stage; hold it while the stage stalls
    always_comb begin
        vld_next = vld_reg;
        if (stage_en[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            if (stage_en[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    ndc_date_lane u_lane_cur (
        .aclk     (aclk),
        .stage_en (stage_en[LANE_STAGES-1:0]),
        .date_in  (s_current_date),
        .result   (cur_res)
    );

    ndc_date_lane u_lane_fst (
        .aclk     (aclk),
        .stage_en (stage_en[LANE_STAGES-1:0]),
        .date_in  (s_first_date),
        .result   (fst_res)
    );

    ndc_date_lane u_lane_snd (
        .aclk     (aclk),
        .stage_en (stage_en[LANE_STAGES-1:0]),
        .date_in  (s_second_date),
        .result   (snd_res)
    );

    ndc_compare u_compare (
        .aclk       (aclk),
        .stage_en   (stage_en[PIPE_DEPTH-1:LANE_STAGES]),
        .cur        (cur_res),
        .fst        (fst_res),
        .snd        (snd_res),
        .current_ok (m_current_ok),
        .first_ok   (m_first_ok),
        .second_ok  (m_second_ok),
        .verdict    (verdict)
    );

    assign m_valid   = vld_reg[PIPE_DEPTH-1];
    assign m_verdict = verdict;

    // A bubble anywhere in the pipe lets a new transaction in
    a_bubble_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg != {PIPE_DEPTH{1'b1}}) |-> s_ready)
        else $error("s_ready low while the pipe holds a bubble");

    // A full pipe accepts exactly when the result side takes one
    a_full_follows_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg == {PIPE_DEPTH{1'b1}}) |-> (s_ready == m_ready))
        else $error("full pipe ready does not follow m_ready");

    // An accepted transaction shows up in the first stage next cycle
    a_entry_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted transaction lost at pipe entry");

endmodule
